@@ design/grff_pkg.sv @@
// ---------------------------------------------------------------------------
// grff_pkg: shared types and constants for the grid region flood fill
// cell layout, payload structs and command codes
// ---------------------------------------------------------------------------
package grff_pkg;
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int IDX_W       = $clog2(CELL_COUNT);
    localparam int CNT_W       = IDX_W + 1;
    localparam int QUEUE_DEPTH = 16384;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] x_pos;
        logic [6:0] y_pos;
        logic [9:0] tile_value;
        logic [1:0] collision_value;
        logic [3:0] elevation_value;
    } t_in_item;

    typedef struct packed {
        logic        in_bounds;
        logic [9:0]  tile_out;
        logic [1:0]  collision_out;
        logic [3:0]  elevation_out;
        logic [14:0] cells_changed;
    } t_out_item;

    // fill queue entry: column and row of a recolored cell
    typedef struct packed {
        logic [6:0] y;
        logic [6:0] x;
    } t_pos;
endpackage

@@ design/grid_region_flood_fill.sv @@
// ---------------------------------------------------------------------------
// grid_region_flood_fill: map cell store with 4-connected region recolor
// cell store and fill queue held in synchronous memories
// ---------------------------------------------------------------------------
// One item at a time: the input stalls from acceptance until the result beat
// has been taken. A write or read passes through address, memory read,
// evaluate and writeback, and output register; an out-of-bounds item goes
// straight to the output register. A fill whose seed changes writes and queues
// the seed, then dequeues each recolored cell and reads each in-bounds
// neighbour, then compares and writes it back on a match (out-of-bounds ones
// are skipped); the single port of the cell memory serializes these accesses.
// Queue entries carry column and row, so no division by the width is needed.
// Map width/height are written through the APB port at 0x0 and 0x4; the user
// must change them only while the block is idle, which it does not enforce.
module grid_region_flood_fill (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  grff_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output grff_pkg::t_out_item  o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import grff_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_EVAL  = 11'b00000000100,
        S_SEED  = 11'b00000001000,
        S_POP   = 11'b00000010000,
        S_PWAIT = 11'b00000100000,
        S_NRD   = 11'b00001000000,
        S_NCHK  = 11'b00010000000,
        S_FRD   = 11'b00100000000,
        S_FWAIT = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    logic [7:0] r_width, r_height;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {24'd0, r_height} : {24'd0, r_width};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 8'd1;
            r_height <= 8'd1;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) r_height <= pwdata[7:0];
            else          r_width  <= pwdata[7:0];
        end
    end
    logic [7:0] w_eff, h_eff;
    assign w_eff = (r_width  > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : r_width;
    assign h_eff = (r_height > 8'(MAX_ROWS))    ? 8'(MAX_ROWS)    : r_height;

    // memories
    logic [15:0]       cell_mem [CELL_COUNT];
    t_pos              queue_mem [QUEUE_DEPTH];
    logic [15:0]       r_cell_q;
    t_pos              r_queue_q;
    logic              c_we, c_re, q_we, q_re;
    logic [IDX_W-1:0]  c_addr;
    logic [QPTR_W-1:0] q_waddr, q_raddr;
    logic [15:0]       c_wdata;
    t_pos              q_wdata;
    always_ff @(posedge i_clk) begin
        if (c_we) cell_mem[c_addr] <= c_wdata;
        if (c_re) r_cell_q <= cell_mem[c_addr];
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        if (q_re) r_queue_q <= queue_mem[q_raddr];
    end

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic              r_inb;
    logic [IDX_W-1:0]  r_idx;
    logic [5:0]        r_old;
    logic [QCNT_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0]  r_changed;
    logic [6:0]        r_cx, r_cy;
    logic [1:0]        r_dir;
    logic [IDX_W-1:0]  r_nidx;
    t_pos              r_npos;
    logic              r_oval;
    t_out_item         r_out;

    logic [5:0]  new_pair;
    logic [15:0] new_cell;
    logic        inb;
    logic [IDX_W-1:0] in_idx;
    assign new_pair = {i_item.elevation_value, i_item.collision_value};
    assign inb = ({1'b0, i_item.x_pos} < w_eff) && ({1'b0, i_item.y_pos} < h_eff);
    assign in_idx = IDX_W'(i_item.y_pos) * IDX_W'(w_eff) + IDX_W'(i_item.x_pos);
    assign new_cell = {r_item.elevation_value, r_item.collision_value, r_item.tile_value};

    // neighbour candidate of the current cell, per direction
    logic       nb_ok;
    logic [6:0] nx, ny;
    always_comb begin
        nx = r_cx; ny = r_cy; nb_ok = 1'b0;
        case (r_dir)
            2'd0: begin nx = r_cx + 7'd1; nb_ok = ({1'b0, r_cx} + 8'd1) < w_eff; end
            2'd1: begin nx = r_cx - 7'd1; nb_ok = r_cx != 7'd0; end
            2'd2: begin ny = r_cy + 7'd1; nb_ok = ({1'b0, r_cy} + 8'd1) < h_eff; end
            default: begin ny = r_cy - 7'd1; nb_ok = r_cy != 7'd0; end
        endcase
    end
    logic [IDX_W-1:0] nb_idx;
    assign nb_idx = IDX_W'(ny) * IDX_W'(w_eff) + IDX_W'(nx);

    assign o_stall = r_state != S_IDLE || r_oval;
    assign o_valid = r_oval;
    assign o_item  = r_out;

    always_comb begin
        n_state = r_state;
        c_we = 1'b0; c_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
        c_addr = r_idx; c_wdata = new_cell;
        q_waddr = r_tail[QPTR_W-1:0]; q_raddr = r_head[QPTR_W-1:0];
        q_wdata = {r_item.y_pos, r_item.x_pos};
        unique case (r_state)
            S_IDLE:  if (i_valid && !o_stall) n_state = inb ? S_RD : S_DONE;
            S_RD:    begin c_re = 1'b1; n_state = S_EVAL; end
            S_EVAL: begin
                if (t_cmd'(r_item.command) == CMD_WRITE) begin
                    c_we = 1'b1;
                    n_state = S_DONE;
                end else if (t_cmd'(r_item.command) == CMD_FILL &&
                             r_cell_q[15:10] != {r_item.elevation_value,
                                                 r_item.collision_value}) begin
                    n_state = S_SEED;
                end else n_state = S_DONE;
            end
            S_SEED: begin
                c_we = 1'b1;
                c_wdata = {r_item.elevation_value, r_item.collision_value, r_cell_q[9:0]};
                q_we = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (r_head == r_tail) n_state = S_FRD;
                else begin q_re = 1'b1; n_state = S_PWAIT; end
            end
            S_PWAIT: n_state = S_NRD;
            S_NRD: begin
                if (nb_ok) begin
                    c_addr = nb_idx; c_re = 1'b1; n_state = S_NCHK;
                end else if (r_dir == 2'd3) n_state = S_POP;
            end
            S_NCHK: begin
                c_addr = r_nidx;
                if (r_cell_q[15:10] == r_old) begin
                    c_we = 1'b1;
                    c_wdata = {r_item.elevation_value, r_item.collision_value,
                               r_cell_q[9:0]};
                    q_we = 1'b1;
                    q_wdata = r_npos;
                end
                n_state = (r_dir == 2'd3) ? S_POP : S_NRD;
            end
            S_FRD:   begin c_re = 1'b1; n_state = S_FWAIT; end
            S_FWAIT: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) r_oval <= 1'b1;
            else if (r_oval && !i_stall) r_oval <= 1'b0;
            if (r_state == S_EVAL) begin
                r_head <= '0;
                r_tail <= '0;
            end else begin
                if (q_we) r_tail <= r_tail + QCNT_W'(1);
                if (q_re) r_head <= r_head + QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !o_stall) begin
            r_item <= i_item; r_inb <= inb; r_idx <= in_idx; r_changed <= '0;
        end
        if (r_state == S_EVAL) begin
            r_old <= r_cell_q[15:10];
            r_changed <= (t_cmd'(r_item.command) == CMD_WRITE && r_cell_q != new_cell)
                         ? CNT_W'(1) : '0;
        end
        if (r_state == S_SEED) r_changed <= CNT_W'(1);
        if (r_state == S_NCHK && r_cell_q[15:10] == r_old)
            r_changed <= r_changed + CNT_W'(1);
        if (r_state == S_PWAIT) begin
            r_cx <= r_queue_q.x; r_cy <= r_queue_q.y; r_dir <= 2'd0;
        end
        if (r_state == S_NRD) begin
            if (nb_ok) begin
                r_nidx <= nb_idx;
                r_npos <= {ny, nx};
            end else if (r_dir != 2'd3) r_dir <= r_dir + 2'd1;
        end
        if (r_state == S_NCHK) r_dir <= r_dir + 2'd1;
        if (r_state == S_DONE) begin
            // a write echoes the cell as stored
            r_out.in_bounds     <= r_inb;
            r_out.tile_out      <= !r_inb ? '0 :
                (t_cmd'(r_item.command) == CMD_WRITE) ? r_item.tile_value : r_cell_q[9:0];
            r_out.collision_out <= !r_inb ? '0 :
                (t_cmd'(r_item.command) == CMD_WRITE) ? r_item.collision_value
                                                      : r_cell_q[11:10];
            r_out.elevation_out <= !r_inb ? '0 :
                (t_cmd'(r_item.command) == CMD_WRITE) ? r_item.elevation_value
                                                      : r_cell_q[15:12];
            r_out.cells_changed <= r_inb ? r_changed : '0;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && i_stall |=> r_oval) else $error("result dropped");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PWAIT |-> r_head <= r_tail) else $error("queue underflow");
endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench for grid_region_flood_fill
// drives cell writes, reads and region fills over several map sizes, predicts
// each result from a local copy of the grid and checks it field by field
// ---------------------------------------------------------------------------
module tb_top;
    import grff_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_region_flood_fill uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // local copy of the grid and dimension registers
    logic [15:0] grid_model [CELL_COUNT];
    bit          grid_known [CELL_COUNT];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    int          fill_list [CELL_COUNT];

    t_out_item   pending_results [$];
    bit          changed_checks [$];
    bit          pred_changed_known;
    int          error_count;
    int          result_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL grid_region_flood_fill");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, result_count);
        error_count++;
    endtask

    function automatic int eff_w();
        return (width_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(width_reg);
    endfunction

    function automatic int eff_h();
        return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
    endfunction

    // recolor one neighbour if it carries the old pair; returns 1 if changed
    function automatic int visit_cell(input int idx, input logic [5:0] old_pair,
                                      input logic [5:0] new_pair, inout int tail);
        if (idx >= CELL_COUNT || grid_model[idx][15:10] != old_pair) return 0;
        grid_model[idx][15:10] = new_pair;
        fill_list[tail] = idx;
        tail++;
        return 1;
    endfunction

    // the change flag of a first write to a cell depends on unwritten contents
    function automatic t_out_item predict_item(input t_in_item it);
        t_out_item   r;
        int          w, h, idx, changed, head, tail, cx, cy;
        logic [15:0] nc;
        logic [5:0]  old_pair, new_pair;
        r = '0;
        pred_changed_known = 1'b1;
        w = eff_w();
        h = eff_h();
        if (it.x_pos >= w || it.y_pos >= h) return r;
        idx = int'(it.y_pos) * w + int'(it.x_pos);
        if (idx >= CELL_COUNT) return r;
        changed = 0;
        new_pair = {it.elevation_value, it.collision_value};
        if (it.command == CMD_WRITE) begin
            nc = {new_pair, it.tile_value};
            pred_changed_known = grid_known[idx];
            if (grid_model[idx] != nc) changed = 1;
            grid_model[idx] = nc;
            grid_known[idx] = 1'b1;
        end else if (it.command == CMD_FILL) begin
            old_pair = grid_model[idx][15:10];
            if (old_pair != new_pair) begin
                head = 0;
                tail = 0;
                changed += visit_cell(idx, old_pair, new_pair, tail);
                while (head < tail) begin
                    cx = fill_list[head] % w;
                    cy = fill_list[head] / w;
                    head++;
                    if (cx + 1 < w) changed += visit_cell(cy * w + cx + 1, old_pair, new_pair, tail);
                    if (cx > 0) changed += visit_cell(cy * w + cx - 1, old_pair, new_pair, tail);
                    if (cy + 1 < h) changed += visit_cell((cy + 1) * w + cx, old_pair, new_pair, tail);
                    if (cy > 0) changed += visit_cell((cy - 1) * w + cx, old_pair, new_pair, tail);
                end
            end
        end
        r.in_bounds     = 1'b1;
        r.tile_out      = grid_model[idx][9:0];
        r.collision_out = grid_model[idx][11:10];
        r.elevation_out = grid_model[idx][15:12];
        r.cells_changed = changed[14:0];
        return r;
    endfunction

    // every cell a fill could touch must be written; reads likewise
    function automatic bit grid_covered(input int w, input int h);
        for (int i = 0; i < w * h && i < CELL_COUNT; i++)
            if (!grid_known[i]) return 0;
        return 1;
    endfunction

    // sender side: one beat, predicted at acceptance; valid is dropped by the
    // next idle cycle or by wait_drained
    task automatic send_item(input t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_item(it));
        changed_checks.push_back(pred_changed_known);
    endtask

    // receiver side: random stall plus a counted hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        bit        check_chg;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                check_chg = changed_checks.pop_front();
                if (o_item.in_bounds !== want.in_bounds)
                    report_mismatch("in_bounds", o_item.in_bounds, want.in_bounds);
                if (o_item.tile_out !== want.tile_out)
                    report_mismatch("tile_out", o_item.tile_out, want.tile_out);
                if (o_item.collision_out !== want.collision_out)
                    report_mismatch("collision_out", o_item.collision_out, want.collision_out);
                if (o_item.elevation_out !== want.elevation_out)
                    report_mismatch("elevation_out", o_item.elevation_out, want.elevation_out);
                if (check_chg && o_item.cells_changed !== want.cells_changed)
                    report_mismatch("cells_changed", o_item.cells_changed, want.cells_changed);
            end
            result_count++;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // leaves psel high so a second write can follow at once
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [7:0] w, input logic [7:0] h);
        wait_drained();
        apb_write(3'h0, {24'd0, w});
        apb_write(3'h4, {24'd0, h});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    function automatic t_in_item make_item(input t_cmd c, input int x, input int y,
                                           input int tile, input int coll, input int elev);
        t_in_item it;
        it.command         = c;
        it.x_pos           = x[6:0];
        it.y_pos           = y[6:0];
        it.tile_value      = tile[9:0];
        it.collision_value = coll[1:0];
        it.elevation_value = elev[3:0];
        return it;
    endfunction

    // write every cell of the current map with a few pairs so fills find regions
    task automatic paint_map(input int npairs);
        int w, h;
        w = eff_w();
        h = eff_h();
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_item(make_item(CMD_WRITE, x, y, $urandom_range(1023),
                                    $urandom_range(npairs - 1), 0));
    endtask

    task automatic test_directed();
        set_dims(8'd1, 8'd1);
        send_item(make_item(CMD_WRITE, 0, 0, 1023, 3, 15));
        send_item(make_item(CMD_WRITE, 0, 0, 1023, 3, 15));   // same contents
        send_item(make_item(CMD_READ, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SPARE, 0, 0, 5, 1, 1));       // spare code reads
        send_item(make_item(CMD_FILL, 0, 0, 0, 3, 15));       // already holds pair
        send_item(make_item(CMD_FILL, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_WRITE, 127, 127, 1023, 3, 15)); // out of bounds
        send_item(make_item(CMD_FILL, 1, 0, 0, 1, 1));
        set_dims(8'd0, 8'd5);                                   // zero width
        send_item(make_item(CMD_READ, 0, 0, 0, 0, 0));
        set_dims(8'd4, 8'd3);
        paint_map(1);
        send_item(make_item(CMD_FILL, 2, 1, 0, 2, 9));          // whole map
        send_item(make_item(CMD_READ, 3, 2, 0, 0, 0));
        send_item(make_item(CMD_READ, 4, 0, 0, 0, 0));
        send_item(make_item(CMD_WRITE, 0, 3, 0, 0, 0));
    endtask

    task automatic test_random(input int n_items, input int max_dim);
        int w, h, r;
        logic [7:0] wr, hr;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0) begin
                r = $urandom_range(9);
                // one saturated row, zero width, one saturated column, or random
                wr = (r == 0) ? 8'd255 : (r == 1) ? 8'd0 : (r == 2) ? 8'd1 :
                     8'($urandom_range(1, max_dim));
                hr = (r == 0) ? 8'd1 : (r == 2) ? 8'd200 : 8'($urandom_range(1, max_dim));
                set_dims(wr, hr);
                paint_map($urandom_range(1, 4));
            end
            w = eff_w();
            h = eff_h();
            r = $urandom_range(99);
            if (w == 0 || h == 0 || !grid_covered(w, h) || r < 8) begin
                send_item(make_item(t_cmd'($urandom_range(3)), $urandom_range(127),
                          $urandom_range(127), $urandom_range(1023), $urandom_range(3),
                          $urandom_range(15)));
            end else if (r < 45) begin
                send_item(make_item(CMD_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
                          $urandom_range(1023), $urandom_range(3), $urandom_range(15)));
            end else if (r < 70) begin
                send_item(make_item(t_cmd'(r[0] ? CMD_READ : CMD_SPARE), $urandom_range(w - 1),
                          $urandom_range(h - 1), $urandom_range(1023), $urandom_range(3),
                          $urandom_range(15)));
            end else begin
                send_item(make_item(CMD_FILL, $urandom_range(w - 1), $urandom_range(h - 1),
                          $urandom_range(1023), $urandom_range(3), $urandom_range(1)));
            end
        end
    endtask

    task automatic test_backpressure();
        set_dims(8'd3, 8'd3);
        paint_map(2);
        hold_cycles <= 400;
        for (int i = 0; i < 20; i++)
            send_item(make_item(CMD_READ, $urandom_range(2), $urandom_range(2), 0, 0, 0));
    endtask

    task automatic test_wide_map();
        set_dims(8'd200, 8'd2);                                 // width saturates
        paint_map(1);
        send_item(make_item(CMD_FILL, 127, 1, 0, 3, 15));       // all 256 cells
        send_item(make_item(CMD_READ, 0, 0, 0, 0, 0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        width_reg  = 8'd1;
        height_reg = 8'd1;
        error_count  = 0;
        result_count = 0;
        cycle_count  = 0;
        hold_cycles  = 0;
        send_idle_pct = 9;
        recv_idle_pct = 61;
        for (int i = 0; i < CELL_COUNT; i++) begin
            grid_model[i] = '0;
            grid_known[i] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(260, 8);
        send_idle_pct = 61;
        recv_idle_pct = 9;
        test_random(260, 8);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(260, 8);
        test_wide_map();
        wait_drained();

        $display("covered writes, reads, spare code, fills and out-of-bounds over %0d results",
                 result_count);
        $display("map sizes from zero width up to saturated rows, with stalls on both sides");
        if (error_count == 0) begin
            $display("PASS grid_region_flood_fill");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL grid_region_flood_fill");
        end
        $finish;
    end
endmodule
